// ===== hdl/smx_pkg.sv =====
// Shared constants, types and helper function of the stereo mixer.
package smx_pkg;

    localparam int NUM_SOURCES = 4;
    localparam int MAX_SOURCES = 4;
    localparam int SAMPLE_BITS = 16;

    localparam int Q_BITS = 16;
    localparam int FRAC_BITS = 30;
    localparam logic [Q_BITS-1:0] Q_ONE = Q_BITS'(32768);
    localparam logic [Q_BITS-1:0] Q_HALF = Q_BITS'(16384);

    localparam int PROD_W = 2 * Q_BITS - 1;
    localparam int TERM_W = SAMPLE_BITS + PROD_W;
    localparam int ACC_W = TERM_W + $clog2(NUM_SOURCES) + 1;
    localparam int RES_W = ACC_W - FRAC_BITS;

    localparam int DELAY_W = 32;
    localparam int CFG_W = 64;
    localparam int CFG_IDX_W = 3;

    localparam int IN_DATA_W = ((2 * MAX_SOURCES * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAINS    = 3'd0,
        REG_PANS     = 3'd1,
        REG_MONO     = 3'd2,
        REG_DELAY_LO = 3'd3,
        REG_DELAY_HI = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic               capture;
        logic               delay_load;
        logic [DELAY_W-1:0] delay_value;
    } lane_ctrl_t;

    function automatic logic [Q_BITS-1:0] clamp_q15(input logic [Q_BITS-1:0] v);
        clamp_q15 = (v > Q_ONE) ? Q_ONE : v;
    endfunction

endpackage

// ===== hdl/stereo_mixer_gain_pan_delay.sv =====
// Top level of the stereo mixer with per-source gain, pan and start delay.
//
// Channel   Direction  Contents
// s_        in         one frame beat: left and right sample of each source
// m_        out        one mixed stereo beat plus clip flag
// cfg_      in         register writes: gains, pans, mono mask, start delays
//
// A frame passes the lane capture, product and term registers and the merging
// stage's sum register before its beat is registered; a new frame is taken once
// the last one has moved to the output register. A stalled output holds the lanes
// until its beat is taken. Reset clears config, control state and delay counters.
module stereo_mixer_gain_pan_delay (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // src0_left, src0_right, src1_left, src1_right, ..., src3_right
    input  logic [smx_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mix_left, mix_right
    output logic [smx_pkg::OUT_DATA_W-1:0]      m_tdata,
    // clipped
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [smx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [smx_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int NS = smx_pkg::NUM_SOURCES;
    localparam int SB = smx_pkg::SAMPLE_BITS;
    localparam int QB = smx_pkg::Q_BITS;
    localparam int DW = smx_pkg::DELAY_W;
    localparam logic [1:0] LAST_STAGE = 2'd3;
    localparam int MAXQ = smx_pkg::MAX_SOURCES * QB;

    logic [MAXQ-1:0]            gains_reg;
    logic [MAXQ-1:0]            pans_reg;
    logic [smx_pkg::MAX_SOURCES-1:0] mono_reg;

    logic                       busy_reg;
    logic [1:0]                 stage_reg;
    logic                       m_tvalid_reg;
    logic [smx_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                       m_tuser_reg;

    logic                       accept;
    logic                       done;
    smx_pkg::cfg_reg_t          cfg_sel;
    smx_pkg::lane_ctrl_t        lane_ctrl [NS];
    logic signed [smx_pkg::TERM_W-1:0] term_left [NS];
    logic signed [smx_pkg::TERM_W-1:0] term_right [NS];
    logic [SB-1:0]              mix_left;
    logic [SB-1:0]              mix_right;
    logic                       clipped;

    assign cfg_sel  = smx_pkg::cfg_reg_t'(cfg_index);
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign done     = busy_reg && (stage_reg == LAST_STAGE) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= '0;
            pans_reg  <= '0;
            mono_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_sel)
                smx_pkg::REG_GAINS: begin
                    gains_reg <= cfg_wdata[MAXQ-1:0];
                end
                smx_pkg::REG_PANS: begin
                    pans_reg <= cfg_wdata[MAXQ-1:0];
                end
                smx_pkg::REG_MONO: begin
                    mono_reg <= cfg_wdata[smx_pkg::MAX_SOURCES-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            stage_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg  <= 1'b1;
                stage_reg <= '0;
            end else if (done) begin
                busy_reg <= 1'b0;
            end else if (busy_reg && (stage_reg != LAST_STAGE)) begin
                stage_reg <= stage_reg + 1'b1;
            end
            if (done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_tdata_reg <= smx_pkg::OUT_DATA_W'({mix_right, mix_left});
            m_tuser_reg <= clipped;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_lane
        always_comb begin
            lane_ctrl[i].capture     = accept;
            lane_ctrl[i].delay_load  = cfg_wr_en &&
                (cfg_sel == ((i < 2) ? smx_pkg::REG_DELAY_LO : smx_pkg::REG_DELAY_HI));
            lane_ctrl[i].delay_value = cfg_wdata[DW*(i%2) +: DW];
        end

        smx_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (lane_ctrl[i]),
            .left_in    (s_tdata[2*SB*i +: SB]),
            .right_in   (s_tdata[2*SB*i+SB +: SB]),
            .gain       (gains_reg[QB*i +: QB]),
            .pan        (pans_reg[QB*i +: QB]),
            .mono       (mono_reg[i]),
            .term_left  (term_left[i]),
            .term_right (term_right[i])
        );
    end

    smx_merge u_merge (
        .aclk       (aclk),
        .term_left  (term_left),
        .term_right (term_right),
        .mix_left   (mix_left),
        .mix_right  (mix_right),
        .clipped    (clipped)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/smx_lane.sv =====
// One source lane: start delay countdown, pan law, gain and sample products.
module smx_lane (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  smx_pkg::lane_ctrl_t                  ctrl,
    input  logic [smx_pkg::SAMPLE_BITS-1:0]      left_in,
    input  logic [smx_pkg::SAMPLE_BITS-1:0]      right_in,
    input  logic [smx_pkg::Q_BITS-1:0]           gain,
    input  logic [smx_pkg::Q_BITS-1:0]           pan,
    input  logic                                 mono,
    output logic signed [smx_pkg::TERM_W-1:0]    term_left,
    output logic signed [smx_pkg::TERM_W-1:0]    term_right
);

    localparam int SB = smx_pkg::SAMPLE_BITS;
    localparam int QB = smx_pkg::Q_BITS;
    localparam int PW = smx_pkg::PROD_W;
    localparam int TW = smx_pkg::TERM_W;

    logic [smx_pkg::DELAY_W-1:0] delay_reg;
    logic                        active_reg;
    logic signed [SB-1:0]        samp_l_reg;
    logic signed [SB-1:0]        samp_r_reg;
    logic [QB-1:0]               coef_l_reg;
    logic [QB-1:0]               coef_r_reg;
    logic [QB-1:0]               gain_reg;
    logic [PW-1:0]               prod_l_reg;
    logic [PW-1:0]               prod_r_reg;
    logic signed [TW-1:0]        term_l_reg;
    logic signed [TW-1:0]        term_r_reg;

    logic [QB-1:0]               pan_c;
    logic [QB-1:0]               coef_l_next;
    logic [QB-1:0]               coef_r_next;
    logic [SB-1:0]               samp_r_next;
    logic [2*QB-1:0]             prod_l_full;
    logic [2*QB-1:0]             prod_r_full;
    logic signed [TW:0]          mult_l;
    logic signed [TW:0]          mult_r;

    always_comb begin
        pan_c = smx_pkg::clamp_q15(pan);
        coef_l_next = smx_pkg::Q_ONE;
        coef_r_next = smx_pkg::Q_ONE;
        samp_r_next = right_in;
        if (mono) begin
            samp_r_next = left_in;
            if (pan_c <= smx_pkg::Q_HALF) begin
                coef_r_next = QB'(pan_c << 1);
            end else begin
                coef_l_next = QB'((smx_pkg::Q_ONE - pan_c) << 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= '0;
        end else if (ctrl.delay_load) begin
            delay_reg <= ctrl.delay_value;
        end else if (ctrl.capture && (delay_reg != '0)) begin
            delay_reg <= delay_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            active_reg <= (delay_reg == '0);
            samp_l_reg <= left_in;
            samp_r_reg <= samp_r_next;
            coef_l_reg <= coef_l_next;
            coef_r_reg <= coef_r_next;
            gain_reg   <= smx_pkg::clamp_q15(gain);
        end
    end

    assign prod_l_full = coef_l_reg * gain_reg;
    assign prod_r_full = coef_r_reg * gain_reg;
    assign mult_l = samp_l_reg * $signed({1'b0, prod_l_reg});
    assign mult_r = samp_r_reg * $signed({1'b0, prod_r_reg});

    always_ff @(posedge aclk) begin
        prod_l_reg <= prod_l_full[PW-1:0];
        prod_r_reg <= prod_r_full[PW-1:0];
        term_l_reg <= active_reg ? mult_l[TW-1:0] : '0;
        term_r_reg <= active_reg ? mult_r[TW-1:0] : '0;
    end

    assign term_left  = term_l_reg;
    assign term_right = term_r_reg;

endmodule

// ===== hdl/smx_merge.sv =====
// Merging stage: sums the lane terms, rounds from Q30 and saturates.
module smx_merge (
    input  logic                                 aclk,
    input  logic signed [smx_pkg::TERM_W-1:0]    term_left [smx_pkg::NUM_SOURCES],
    input  logic signed [smx_pkg::TERM_W-1:0]    term_right [smx_pkg::NUM_SOURCES],
    output logic [smx_pkg::SAMPLE_BITS-1:0]      mix_left,
    output logic [smx_pkg::SAMPLE_BITS-1:0]      mix_right,
    output logic                                 clipped
);

    localparam int AW = smx_pkg::ACC_W;
    localparam int RW = smx_pkg::RES_W;
    localparam int SB = smx_pkg::SAMPLE_BITS;
    localparam int FB = smx_pkg::FRAC_BITS;
    localparam logic signed [AW-1:0] ROUND_BIAS = AW'(1) <<< (FB - 1);
    localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (SB - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

    logic signed [AW-1:0] sum_l_reg;
    logic signed [AW-1:0] sum_r_reg;
    logic signed [AW-1:0] sum_l_next;
    logic signed [AW-1:0] sum_r_next;
    logic signed [AW-1:0] rnd_l;
    logic signed [AW-1:0] rnd_r;
    logic signed [RW-1:0] res_l;
    logic signed [RW-1:0] res_r;
    logic                 clip_l;
    logic                 clip_r;

    always_comb begin
        sum_l_next = '0;
        sum_r_next = '0;
        for (int i = 0; i < smx_pkg::NUM_SOURCES; i++) begin
            sum_l_next = sum_l_next + AW'(term_left[i]);
            sum_r_next = sum_r_next + AW'(term_right[i]);
        end
    end

    always_ff @(posedge aclk) begin
        sum_l_reg <= sum_l_next;
        sum_r_reg <= sum_r_next;
    end

    always_comb begin
        rnd_l = sum_l_reg + ROUND_BIAS;
        rnd_r = sum_r_reg + ROUND_BIAS;
        res_l = $signed(rnd_l[AW-1:FB]);
        res_r = $signed(rnd_r[AW-1:FB]);
        clip_l = (res_l > SAT_HI) || (res_l < SAT_LO);
        clip_r = (res_r > SAT_HI) || (res_r < SAT_LO);
        if (res_l > SAT_HI) begin
            mix_left = SAT_HI[SB-1:0];
        end else if (res_l < SAT_LO) begin
            mix_left = SAT_LO[SB-1:0];
        end else begin
            mix_left = res_l[SB-1:0];
        end
        if (res_r > SAT_HI) begin
            mix_right = SAT_HI[SB-1:0];
        end else if (res_r < SAT_LO) begin
            mix_right = SAT_LO[SB-1:0];
        end else begin
            mix_right = res_r[SB-1:0];
        end
        clipped = clip_l || clip_r;
    end

endmodule
